// File: sv/dsc_pkg.sv
`timescale 1ns / 1ps

package dsc_pkg;

   localparam int MAX_ENTRIES_DEFAULT   = 512;
   localparam int MAX_ENTRY_LEN_DEFAULT = 8;
   localparam int COUNT_BITS_DEFAULT    = 16;
   localparam int SYMBOL_BITS           = 8;
   localparam int OUT_COUNT_BITS        = 16;

   typedef enum logic [1:0] {
      REQ_DICT    = 2'd0,
      REQ_PATTERN = 2'd1,
      REQ_CLEAR   = 2'd2,
      REQ_EMPTY   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic [1:0]             req_type;
      logic [SYMBOL_BITS-1:0] symbol;
      logic                   last;
   } req_payload_type;

   typedef struct packed {
      logic                      possible;
      logic [OUT_COUNT_BITS-1:0] made_count;
      logic                      table_overflow;
   } rsp_payload_type;

   typedef struct packed {
      logic accept;
      logic scan_issue;
      logic hist_update;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_end;
      logic hit;
      logic pend;
      logic pat_last;
      logic out_busy;
   } ctrl_status_type;

endpackage

// File: sv/dsc_chan_if.sv
`timescale 1ns / 1ps

interface dsc_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/dictionary_segmentation_check_top.sv
`timescale 1ns / 1ps
// dictionary symbol and clear items produce no result
// pattern symbol: scans the stored entries, one stored entry read per cycle
// from the entry ram, stopping early at the first match; a final symbol then emits a result
// empty pattern emits a result; a result waits in the output register until taken
// synchronous active-high reset clears control state and counters; entry ram is not cleared

module dictionary_segmentation_check_top #(
   parameter int MAX_ENTRIES   = dsc_pkg::MAX_ENTRIES_DEFAULT,
   parameter int MAX_ENTRY_LEN = dsc_pkg::MAX_ENTRY_LEN_DEFAULT,
   parameter int COUNT_BITS    = dsc_pkg::COUNT_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   dsc_chan_if.sink   req_ch,
   dsc_chan_if.source rsp_ch
);
   import dsc_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;
   logic            req_ready;
   logic            rsp_valid;

   assign req_payload    = req_ch.payload;
   assign req_ch.ready   = req_ready;
   assign rsp_ch.valid   = rsp_valid;
   assign rsp_ch.payload = rsp_payload;

   dsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_payload.req_type),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dsc_datapath #(
      .MAX_ENTRIES   (MAX_ENTRIES),
      .MAX_ENTRY_LEN (MAX_ENTRY_LEN),
      .COUNT_BITS    (COUNT_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_payload (rsp_payload)
   );
endmodule

// File: sv/dsc_ram.sv
`timescale 1ns / 1ps

module dsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: sv/dsc_ctrl.sv
`timescale 1ns / 1ps

module dsc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [1:0]               req_kind,
   output logic                     req_ready,
   input  dsc_pkg::ctrl_status_type status,
   output dsc_pkg::ctrl_cmd_type    cmd
);
   import dsc_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_kind)
                  REQ_PATTERN: state_in = ST_SCAN;
                  REQ_EMPTY:   state_in = ST_EMIT;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = !status.scan_end && !status.hit;
            if ((status.scan_end || status.hit) && !status.pend) begin
               cmd.hist_update = 1'b1;
               state_in        = status.pat_last ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

// File: sv/dsc_datapath.sv
`timescale 1ns / 1ps

module dsc_datapath #(
   parameter int MAX_ENTRIES   = 512,
   parameter int MAX_ENTRY_LEN = 8,
   parameter int COUNT_BITS    = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dsc_pkg::ctrl_cmd_type    cmd,
   input  dsc_pkg::req_payload_type req_payload,
   output dsc_pkg::ctrl_status_type status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output dsc_pkg::rsp_payload_type rsp_payload
);
   import dsc_pkg::*;

   localparam int LEN_BITS  = $clog2(MAX_ENTRY_LEN + 1);
   localparam int ADDR_BITS = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_BITS  = $clog2(MAX_ENTRIES + 1);
   localparam int SYM_BITS  = MAX_ENTRY_LEN * SYMBOL_BITS;
   localparam int ROW_BITS  = SYM_BITS + LEN_BITS;

   typedef logic [MAX_ENTRY_LEN-1:0][SYMBOL_BITS-1:0] window_type;

   window_type                 recent_ff, recent_in;
   window_type                 load_buf_ff, load_buf_in;
   logic [MAX_ENTRY_LEN:0]     hist_ff, hist_in;
   logic [LEN_BITS-1:0]        load_pos_ff, load_pos_in;
   logic                       load_drop_ff, load_drop_in;
   logic [CNT_BITS-1:0]        entry_count_ff, entry_count_in;
   logic [CNT_BITS-1:0]        scan_addr_ff, scan_addr_in;
   logic                       hit_ff, hit_in;
   logic                       pend_ff;
   logic                       kind_empty_ff, kind_empty_in;
   logic                       pat_last_ff, pat_last_in;
   logic [COUNT_BITS-1:0]      total_ff, total_in;
   logic                       overflow_ff, overflow_in;
   logic                       out_valid_ff, out_valid_in;
   rsp_payload_type            out_ff, out_in;

   logic                       wr_en;
   logic [ROW_BITS-1:0]        wr_data;
   logic [ROW_BITS-1:0]        rd_data;
   logic [LEN_BITS-1:0]        pos_next;
   logic                       drop_next;
   logic [LEN_BITS-1:0]        row_len;
   logic [LEN_BITS-1:0]        len_m1;
   window_type                 row_syms;
   logic                       sym_ok;
   logic                       match;
   logic                       ok;

   dsc_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (MAX_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (entry_count_ff[ADDR_BITS-1:0]),
      .wr_data (wr_data),
      .rd_en   (cmd.scan_issue),
      .rd_addr (scan_addr_ff[ADDR_BITS-1:0]),
      .rd_data (rd_data)
   );

   // entry row holds symbols newest-first, aligned with the window
   assign row_len  = rd_data[ROW_BITS-1 -: LEN_BITS];
   assign row_syms = rd_data[SYM_BITS-1:0];
   assign len_m1   = row_len - 1'b1;

   always_comb begin
      sym_ok = 1'b1;
      for (int j = 0; j < MAX_ENTRY_LEN; j++) begin
         if ((j < int'(row_len)) && (row_syms[j] != recent_ff[j])) begin
            sym_ok = 1'b0;
         end
      end
   end

   assign match = pend_ff && (row_len != '0) && hist_ff[len_m1] && sym_ok;
   assign ok    = kind_empty_ff || hist_ff[0];

   always_comb begin
      recent_in      = recent_ff;
      load_buf_in    = load_buf_ff;
      hist_in        = hist_ff;
      load_pos_in    = load_pos_ff;
      load_drop_in   = load_drop_ff;
      entry_count_in = entry_count_ff;
      scan_addr_in   = scan_addr_ff;
      hit_in         = hit_ff | match;
      kind_empty_in  = kind_empty_ff;
      pat_last_in    = pat_last_ff;
      total_in       = total_ff;
      overflow_in    = overflow_ff;
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_in         = out_ff;
      wr_en          = 1'b0;
      pos_next       = load_pos_ff;
      drop_next      = load_drop_ff;

      for (int j = MAX_ENTRY_LEN - 1; j > 0; j--) begin
         load_buf_in[j] = load_buf_ff[j-1];
      end
      load_buf_in[0] = req_payload.symbol;
      if (!cmd.accept || (req_payload.req_type != REQ_DICT)) begin
         load_buf_in = load_buf_ff;
      end

      if (cmd.accept) begin
         kind_empty_in = (req_payload.req_type == REQ_EMPTY);
         pat_last_in   = req_payload.last;
         case (req_payload.req_type)
            REQ_DICT: begin
               if (load_pos_ff < LEN_BITS'(MAX_ENTRY_LEN)) begin
                  pos_next = load_pos_ff + 1'b1;
               end else begin
                  drop_next   = 1'b1;
                  load_buf_in = load_buf_ff;
               end
               if (req_payload.last) begin
                  if (drop_next || (entry_count_ff >= CNT_BITS'(MAX_ENTRIES))) begin
                     overflow_in = 1'b1;
                  end else begin
                     wr_en          = 1'b1;
                     entry_count_in = entry_count_ff + 1'b1;
                  end
                  load_pos_in  = '0;
                  load_drop_in = 1'b0;
               end else begin
                  load_pos_in  = pos_next;
                  load_drop_in = drop_next;
               end
            end
            REQ_PATTERN: begin
               for (int j = MAX_ENTRY_LEN - 1; j > 0; j--) begin
                  recent_in[j] = recent_ff[j-1];
               end
               recent_in[0] = req_payload.symbol;
               scan_addr_in = '0;
               hit_in       = 1'b0;
            end
            REQ_CLEAR: begin
               entry_count_in = '0;
               load_pos_in    = '0;
               load_drop_in   = 1'b0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.scan_issue) begin
         scan_addr_in = scan_addr_ff + 1'b1;
      end

      if (cmd.hist_update) begin
         hist_in = {hist_ff[MAX_ENTRY_LEN-1:0], hit_ff};
      end

      if (cmd.emit) begin
         if (ok && (total_ff != {COUNT_BITS{1'b1}})) begin
            total_in = total_ff + 1'b1;
         end
         out_in.possible       = ok;
         out_in.made_count     = OUT_COUNT_BITS'(total_in);
         out_in.table_overflow = overflow_ff;
         out_valid_in          = 1'b1;
         recent_in             = '0;
         hist_in               = {{MAX_ENTRY_LEN{1'b0}}, 1'b1};
      end
   end

   assign wr_data = {pos_next, load_buf_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff      <= '0;
         hist_ff        <= {{MAX_ENTRY_LEN{1'b0}}, 1'b1};
         load_pos_ff    <= '0;
         load_drop_ff   <= 1'b0;
         entry_count_ff <= '0;
         scan_addr_ff   <= '0;
         hit_ff         <= 1'b0;
         pend_ff        <= 1'b0;
         kind_empty_ff  <= 1'b0;
         pat_last_ff    <= 1'b0;
         total_ff       <= '0;
         overflow_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         recent_ff      <= recent_in;
         hist_ff        <= hist_in;
         load_pos_ff    <= load_pos_in;
         load_drop_ff   <= load_drop_in;
         entry_count_ff <= entry_count_in;
         scan_addr_ff   <= scan_addr_in;
         hit_ff         <= hit_in;
         pend_ff        <= cmd.scan_issue;
         kind_empty_ff  <= kind_empty_in;
         pat_last_ff    <= pat_last_in;
         total_ff       <= total_in;
         overflow_ff    <= overflow_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      load_buf_ff <= load_buf_in;
      out_ff      <= out_in;
   end

   assign status.scan_end = (scan_addr_ff == entry_count_ff);
   assign status.hit      = hit_ff;
   assign status.pend     = pend_ff;
   assign status.pat_last = pat_last_ff;
   assign status.out_busy = out_valid_ff && !rsp_ready;

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;
endmodule

// File: dv/dictionary_segmentation_check_top_tb.sv
`timescale 1ns / 1ps

module dictionary_segmentation_check_top_tb;
   import dsc_pkg::*;

   localparam int MAX_ENT    = MAX_ENTRIES_DEFAULT;
   localparam int MAX_LEN    = MAX_ENTRY_LEN_DEFAULT;
   localparam int COUNT_BITS = COUNT_BITS_DEFAULT;
   localparam int RANDOM_ITEMS = 150;
   localparam int CALM_TAIL    = 40;
   localparam int HOLD_AFTER   = 60;
   localparam int LONG_HOLD    = 250;
   localparam int QUIET_LIMIT  = 4000;
   localparam int SETTLE       = 40;

   typedef struct packed {
      logic            wait_idle;
      req_payload_type item;
   } stim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic            drv_valid   = 1'b0;
   req_payload_type drv_payload = '0;
   logic            take_ready  = 1'b0;

   dsc_chan_if #(.payload_type(req_payload_type)) req_ch ();
   dsc_chan_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   assign req_ch.valid   = drv_valid;
   assign req_ch.payload = drv_payload;
   assign rsp_ch.ready   = take_ready;

   dictionary_segmentation_check_top #(
      .MAX_ENTRIES  (MAX_ENT),
      .MAX_ENTRY_LEN(MAX_LEN),
      .COUNT_BITS   (COUNT_BITS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [7:0]            dict_sym [MAX_ENT][MAX_LEN];
   int                    dict_len [MAX_ENT];
   int                    dict_n     = 0;
   int                    load_pos   = 0;
   bit                    load_drop  = 1'b0;
   logic [7:0]            window_sym [MAX_LEN];
   logic [MAX_LEN:0]      reach_bits = {{MAX_LEN{1'b0}}, 1'b1};
   logic [COUNT_BITS-1:0] made_total = '0;
   bit                    sticky_ovf = 1'b0;
   rsp_payload_type       verdicts_due[$];

   stim_type stim_q[$];
   int    outstanding   = 0;
   int    items_taken   = 0;
   int    verdicts_seen = 0;
   int    mismatches    = 0;
   bit    calm          = 1'b0;

   function automatic void post_verdict(logic ok);
      rsp_payload_type v;
      if (ok && made_total != {COUNT_BITS{1'b1}}) made_total++;
      v.possible       = ok;
      v.made_count     = OUT_COUNT_BITS'(made_total);
      v.table_overflow = sticky_ovf;
      verdicts_due = {verdicts_due, v};
   endfunction

   function automatic void forget_pattern();
      int k;
      for (k = 0; k < MAX_LEN; k++) window_sym[k] = 8'h00;
      reach_bits = {{MAX_LEN{1'b0}}, 1'b1};
   endfunction

   function automatic void segment_step(req_payload_type p);
      logic hit;
      bit   same;
      int   e;
      int   k;
      int   len;
      hit = 1'b0;
      case (req_code_type'(p.req_type))
         REQ_DICT: begin
            if (load_pos < MAX_LEN) begin
               if (dict_n < MAX_ENT) dict_sym[dict_n][load_pos] = p.symbol;
               load_pos++;
            end else begin
               load_drop = 1'b1;
            end
            if (p.last) begin
               if (load_drop || dict_n >= MAX_ENT) begin
                  sticky_ovf = 1'b1;
               end else begin
                  dict_len[dict_n] = load_pos;
                  dict_n++;
               end
               load_pos  = 0;
               load_drop = 1'b0;
            end
         end
         REQ_CLEAR: begin
            dict_n    = 0;
            load_pos  = 0;
            load_drop = 1'b0;
         end
         REQ_EMPTY: begin
            forget_pattern();
            post_verdict(1'b1);
         end
         REQ_PATTERN: begin
            for (k = MAX_LEN - 1; k > 0; k--) window_sym[k] = window_sym[k-1];
            window_sym[0] = p.symbol;
            for (e = 0; e < dict_n && !hit; e++) begin
               len = dict_len[e];
               if (reach_bits[len-1]) begin
                  same = 1'b1;
                  for (k = 0; k < len; k++)
                     if (dict_sym[e][k] != window_sym[len-1-k]) same = 1'b0;
                  hit = same;
               end
            end
            reach_bits = {reach_bits[MAX_LEN-1:0], hit};
            if (p.last) begin
               hit = reach_bits[0];
               forget_pattern();
               post_verdict(hit);
            end
         end
      endcase
   endfunction

   // stimulus generation
   bit          pause_next = 1'b0;
   logic [7:0]  alpha [3];
   int          alpha_n = 3;
   logic [63:0] word_bits[$];
   int          word_len[$];
   logic [7:0]  pat_syms[$];

   function automatic void put(req_code_type t, logic [7:0] s, logic l);
      stim_type st;
      st.wait_idle      = pause_next;
      st.item.req_type  = t;
      st.item.symbol    = s;
      st.item.last      = l;
      pause_next        = 1'b0;
      stim_q = {stim_q, st};
   endfunction

   function automatic void load_word();
      int          len;
      int          r;
      int          k;
      logic [7:0]  s;
      logic [63:0] bits;
      r = $urandom_range(19);
      if (r < 10)      len = $urandom_range(1, 2);
      else if (r < 17) len = $urandom_range(3, 5);
      else if (r < 19) len = $urandom_range(6, MAX_LEN);
      else             len = $urandom_range(MAX_LEN + 1, MAX_LEN + 2);
      bits = '0;
      for (k = 0; k < len; k++) begin
         s = alpha[$urandom_range(alpha_n - 1)];
         if (k < MAX_LEN) bits[8*k +: 8] = s;
         put(REQ_DICT, s, k == len - 1);
      end
      if (len <= MAX_LEN) begin
         word_bits = {word_bits, bits};
         word_len  = {word_len, len};
      end
   endfunction

   function automatic void new_dictionary();
      int k;
      put(REQ_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
      word_bits.delete();
      word_len.delete();
      alpha_n = $urandom_range(2, 3);
      for (k = 0; k < 3; k++) alpha[k] = 8'($urandom_range(255));
      for (k = $urandom_range(2, 10); k > 0; k--) load_word();
   endfunction

   function automatic void append_words(int n);
      int i;
      int j;
      int k;
      for (i = 0; i < n; i++) begin
         if (word_len.size() == 0) begin
            pat_syms = {pat_syms, alpha[$urandom_range(alpha_n - 1)]};
         end else begin
            j = $urandom_range(word_len.size() - 1);
            for (k = 0; k < word_len[j]; k++) pat_syms = {pat_syms, word_bits[j][8*k +: 8]};
         end
      end
   endfunction

   function automatic void emit_pattern(bit closed);
      int i;
      for (i = 0; i < pat_syms.size(); i++)
         put(REQ_PATTERN, pat_syms[i], closed && i == pat_syms.size() - 1);
      pat_syms.delete();
   endfunction

   function automatic void random_episode();
      int r;
      int k;
      r = $urandom_range(99);
      if (r < 7) begin
         new_dictionary();
      end else if (r < 12) begin
         if (word_len.size() < 24) load_word();
      end else if (r < 62) begin
         append_words($urandom_range(1, 4));
         if ($urandom_range(3) == 0) begin
            k = $urandom_range(pat_syms.size() - 1);
            pat_syms[k] = $urandom_range(1) ? alpha[$urandom_range(alpha_n - 1)]
                                            : 8'($urandom_range(255));
         end
         if (pat_syms.size() > 1 && $urandom_range(9) == 0) void'(pat_syms.pop_back());
         emit_pattern(1'b1);
      end else if (r < 70) begin
         append_words(1);
         emit_pattern(1'b0);
         load_word();
         append_words($urandom_range(1, 2));
         emit_pattern(1'b1);
      end else if (r < 78) begin
         for (k = $urandom_range(1, 6); k > 0; k--)
            pat_syms = {pat_syms, alpha[$urandom_range(alpha_n - 1)]};
         emit_pattern(1'b1);
      end else if (r < 84) begin
         append_words($urandom_range(1, 2));
         emit_pattern(1'b0);
         put(REQ_EMPTY, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (r < 88) begin
         put(REQ_EMPTY, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (r < 94) begin
         put(req_code_type'($urandom_range(3)), 8'($urandom_range(255)),
             1'($urandom_range(1)));
      end else begin
         pause_next = 1'b1;
      end
   endfunction

   initial begin
      int k;
      int mark;

      // directed part
      put(REQ_EMPTY, 8'hFF, 1'b1);
      put(REQ_PATTERN, 8'h00, 1'b1);
      put(REQ_DICT, 8'h00, 1'b1);
      put(REQ_DICT, 8'hFF, 1'b1);
      put(REQ_PATTERN, 8'hFF, 1'b0);
      put(REQ_PATTERN, 8'h00, 1'b0);
      put(REQ_PATTERN, 8'hFF, 1'b1);
      put(REQ_PATTERN, 8'h5A, 1'b0);
      put(REQ_EMPTY, 8'h00, 1'b0);
      // entry loaded mid pattern only counts for later symbols
      put(REQ_PATTERN, 8'h11, 1'b0);
      put(REQ_DICT, 8'h11, 1'b1);
      put(REQ_PATTERN, 8'h11, 1'b1);
      // entry one symbol too long
      for (k = 0; k <= MAX_LEN; k++) put(REQ_DICT, 8'h80 | 8'(k), k == MAX_LEN);
      put(REQ_DICT, 8'h33, 1'b0);
      put(REQ_CLEAR, 8'hA5, 1'b1);
      put(REQ_PATTERN, 8'h00, 1'b1);

      // random part
      mark = stim_q.size();
      pause_next = 1'b1;
      new_dictionary();
      while (stim_q.size() < mark + RANDOM_ITEMS) random_episode();

      // fill the dictionary, then try to go past the end
      pause_next = 1'b1;
      put(REQ_CLEAR, 8'h00, 1'b0);
      for (k = 0; k < MAX_ENT - 1; k++) put(REQ_DICT, 8'($urandom_range(8'h7F)), 1'b1);
      put(REQ_DICT, 8'hC3, 1'b1);
      put(REQ_DICT, 8'hEE, 1'b1);
      put(REQ_PATTERN, 8'hC3, 1'b1);
      put(REQ_PATTERN, 8'hEE, 1'b1);
      put(REQ_PATTERN, 8'($urandom_range(8'h7F)), 1'b0);
      put(REQ_PATTERN, 8'($urandom_range(8'h7F)), 1'b1);

      // closing stretch
      pause_next = 1'b1;
      mark = stim_q.size();
      new_dictionary();
      while (stim_q.size() < mark + CALM_TAIL) random_episode();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (stim_q.size() != 0) @(posedge clock);
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (verdicts_due.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, verdicts_due.size());
      end
      $display("run covered %0d items and %0d pattern results, %0d patterns possible",
               items_taken, verdicts_seen, made_total);
      $display("dictionary loads, clears, overflow drops and empty patterns included");
      if (mismatches == 0 && verdicts_due.size() == 0) begin
         $display("dictionary_segmentation_check_top_tb: PASS");
      end else begin
         $display("dictionary_segmentation_check_top_tb: FAIL");
      end
      $finish;
   end

   // driver
   int gap_left = 0;
   int gap_pct  = 20;
   int gap_mode = 0;

   always @(posedge clock) begin
      logic took;
      took = drv_valid && req_ch.ready;
      if (reset) begin
         drv_valid <= 1'b0;
      end else begin
         if (took) stim_q.delete(0);
         calm     <= stim_q.size() < CALM_TAIL;
         gap_mode <= gap_mode + 1;
         if (gap_mode % 64 == 63) gap_pct <= $urandom_range(2) * 20;
         if (drv_valid && !took) begin
            drv_valid <= 1'b1;
         end else if (gap_left != 0) begin
            gap_left  <= gap_left - 1;
            drv_valid <= 1'b0;
         end else if (stim_q.size() == 0) begin
            drv_valid <= 1'b0;
         end else if (stim_q[0].wait_idle && (drv_valid || outstanding != 0)) begin
            drv_valid <= 1'b0;
         end else if (!calm && $urandom_range(99) < gap_pct) begin
            gap_left  <= $urandom_range(0, 5);
            drv_valid <= 1'b0;
         end else begin
            drv_valid   <= 1'b1;
            drv_payload <= stim_q[0].item;
         end
      end
   end

   // result receiver
   int  stall_left = 0;
   int  stall_pct  = 20;
   int  stall_mode = 0;
   int  hold_left  = 0;
   bit  hold_done  = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         take_ready <= 1'b0;
      end else begin
         stall_mode <= stall_mode + 1;
         if (stall_mode % 64 == 31) stall_pct <= $urandom_range(2) * 20;
         if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            take_ready <= 1'b0;
         end else if (!hold_done && items_taken >= HOLD_AFTER) begin
            hold_done  <= 1'b1;
            hold_left  <= LONG_HOLD - 1;
            take_ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            take_ready <= 1'b0;
         end else if (!calm && $urandom_range(99) < stall_pct) begin
            stall_left <= $urandom_range(0, 5);
            take_ready <= 1'b0;
         end else begin
            take_ready <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            segment_step(req_ch.payload);
            items_taken <= items_taken + 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            verdicts_seen++;
            if (verdicts_due.size() == 0) begin
               $display("%0t: unexpected result possible=%0b count=%0d overflow=%0b",
                        $time, got.possible, got.made_count, got.table_overflow);
               mismatches++;
            end else begin
               want = verdicts_due.pop_front();
               if (got.possible !== want.possible || got.made_count !== want.made_count ||
                   got.table_overflow !== want.table_overflow) begin
                  $display("%0t: mismatch expected possible=%0b count=%0d overflow=%0b, %s",
                           $time, want.possible, want.made_count, want.table_overflow,
                           $sformatf("actual possible=%0b count=%0d overflow=%0b",
                                     got.possible, got.made_count, got.table_overflow));
                  mismatches++;
               end
            end
         end
         outstanding <= verdicts_due.size();
      end
   end

   // watchdog
   int quiet = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet <= 0;
         end else if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("dictionary_segmentation_check_top_tb: FAIL");
            $finish;
         end else begin
            quiet <= quiet + 1;
         end
      end
   end

endmodule
